[rtl/assert_macros.svh]
// Assertion helpers for the modulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check, off while reset is held
`define SVP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("space vector pwm check failed");
// Clocked check, also during reset
`define SVP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("space vector pwm check failed");
`else
`define SVP_ASSERT(lbl, clk, rst_n, prop)
`define SVP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/svpwm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg
// Constants and tables for the six-sector space vector modulator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_ENTRIES      = 24;
    localparam int FRAC_BITS         = 12;
    localparam int VOLT_W            = 16;
    localparam int OUT_W             = 15;
    localparam int CFG_IDX_W         = 2;
    localparam int CFG_DATA_W        = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTERED     = 2'd1;

    localparam logic [OUT_W-1:0] LIMIT_RESET = 15'd24576;

    localparam logic signed [31:0] GAIN_1P5        = 32'sd978049311;
    localparam logic signed [31:0] GAIN_HALF_SQRT3 = 32'sd564677033;
    localparam logic signed [31:0] GAIN_SQRT3      = 32'sd1129354066;

    typedef logic signed [31:0] t_cval;
    typedef logic [31:0]        t_turn32;

    // atan(2^-i) in units of 2^-32 turn
    function automatic t_turn32 atan_ent(input logic [4:0] idx);
        t_turn32 v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // start of each sector, 2^-32 turn
    function automatic t_turn32 sector_base(input logic [2:0] sec0);
        t_turn32 v;
        unique case (sec0)
            3'd0: v = 32'h00000000;
            3'd1: v = 32'h2AAAAAAB;
            3'd2: v = 32'h55555556;
            3'd3: v = 32'h80000001;
            3'd4: v = 32'hAAAAAAAC;
            3'd5: v = 32'hD5555557;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/space_vector_pwm_core.sv]
`timescale 1ns / 1ps
// Path from request accept to result valid: vectoring CORDIC registers, sector find,
// rotation setup and rotating CORDIC registers, gain stage, active times, phase build.
// Throughput: one request per cycle while the output is not stalled.
// A stalled output freezes the whole pipeline in place.
// Synchronous active-low reset clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// space_vector_pwm_core
// Six-sector space vector modulator: vectoring CORDIC for the command angle,
// rotating CORDIC into the sector, gain multiply and phase clamp.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module space_vector_pwm_core #(
    parameter int ANGLE_BITS    = svpwm_pkg::ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = svpwm_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [svpwm_pkg::VOLT_W-1:0]  i_volt_q,
    input  logic signed [svpwm_pkg::VOLT_W-1:0]  i_volt_d,
    input  logic [15:0]                          i_elec_angle,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [svpwm_pkg::OUT_W-1:0]          o_phase_a_volt,
    output logic [svpwm_pkg::OUT_W-1:0]          o_phase_b_volt,
    output logic [svpwm_pkg::OUT_W-1:0]          o_phase_c_volt,
    output logic [2:0]                           o_sector_number,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [svpwm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [svpwm_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import svpwm_pkg::*;

    localparam int N  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int AB = ANGLE_BITS;
    localparam int UP = (AB >= 16) ? AB - 16 : 0;
    localparam int DN = (AB >= 16) ? 0 : 16 - AB;
    localparam logic [32:0] OFF_HALF = 33'(1) << (31 - AB);
    localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

    // ------------------------------------------------------------------ config
    logic [OUT_W-1:0] r_limit;
    logic             r_centered;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit    <= LIMIT_RESET;
            r_centered <= 1'b1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SUPPLY_LIMIT) begin
                r_limit <= i_cfg_data;
            end else if (i_cfg_index == CFG_CENTERED) begin
                r_centered <= i_cfg_data[0];
            end
        end
    end

    // ------------------------------------------------------------ flow control
    logic en;
    logic r_out_valid;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // ------------------------------------------------------ vectoring pipeline
    logic                      r_vv [0:N];
    t_cval                     r_vx [0:N];
    t_cval                     r_vy [0:N];
    t_turn32                   r_vz [0:N];
    logic signed [VOLT_W-1:0]  r_vq [0:N];
    logic signed [VOLT_W-1:0]  r_vd [0:N];
    logic [AB-1:0]             r_vea [0:N];

    t_cval   n_x0, n_y0;
    t_turn32 n_z0;
    logic [AB-1:0] n_ea;

    always_comb begin
        n_x0 = t_cval'(i_volt_d) <<< FRAC_BITS;
        n_y0 = t_cval'(i_volt_q) <<< FRAC_BITS;
        n_z0 = '0;
        if (n_x0 < 0) begin
            n_x0 = -n_x0;
            n_y0 = -n_y0;
            n_z0 = 32'h80000000;
        end
        n_ea = AB'((40'(i_elec_angle) << UP) >> DN);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vv[0] <= 1'b0;
        end else if (en) begin
            r_vv[0] <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vx[0]  <= n_x0;
            r_vy[0]  <= n_y0;
            r_vz[0]  <= n_z0;
            r_vq[0]  <= i_volt_q;
            r_vd[0]  <= i_volt_d;
            r_vea[0] <= n_ea;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_vec
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vv[i+1] <= 1'b0;
            end else if (en) begin
                r_vv[i+1] <= r_vv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_vy[i] >= 0) begin
                    r_vx[i+1] <= r_vx[i] + (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] - (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] + atan_ent(5'(i));
                end else begin
                    r_vx[i+1] <= r_vx[i] - (r_vy[i] >>> i);
                    r_vy[i+1] <= r_vy[i] + (r_vx[i] >>> i);
                    r_vz[i+1] <= r_vz[i] - atan_ent(5'(i));
                end
                r_vq[i+1]  <= r_vq[i];
                r_vd[i+1]  <= r_vd[i];
                r_vea[i+1] <= r_vea[i];
            end
        end
    end

    // ------------------------------------------------------------ sector find
    logic                     r_av;
    logic [2:0]               r_asec;
    logic [AB-1:0]            r_aea;
    logic signed [VOLT_W-1:0] r_aq, r_ad;
    logic [AB-1:0]            n_off, n_theta;
    logic [AB+2:0]            n_six;

    always_comb begin
        if (r_vd[N] != '0) begin
            n_off = AB'((33'(r_vz[N]) + OFF_HALF) >> (32 - AB));
        end else begin
            n_off = QUARTER;
        end
        n_theta = r_vea[N] + n_off;
        n_six   = (AB+3)'(n_theta) * (AB+3)'(6);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (en) begin
            r_av <= r_vv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_asec <= n_six[AB+2:AB];
            r_aea  <= r_vea[N];
            r_aq   <= r_vq[N];
            r_ad   <= r_vd[N];
        end
    end

    // --------------------------------------------------------- rotation setup
    logic       r_rv   [0:N];
    t_cval      r_rx   [0:N];
    t_cval      r_ry   [0:N];
    t_cval      r_rr   [0:N];
    logic [2:0] r_rsec [0:N];

    t_turn32 n_rot, n_rq;
    t_cval   n_bx, n_by, n_rx, n_ry;

    always_comb begin
        n_rot = (t_turn32'(r_aea) << (32 - AB)) - sector_base(r_asec);
        n_rq  = n_rot + 32'h20000000;
        n_bx  = t_cval'(r_ad) <<< FRAC_BITS;
        n_by  = t_cval'(r_aq) <<< FRAC_BITS;
        unique case (n_rq[31:30])
            2'd0: begin n_rx = n_bx;  n_ry = n_by;  end
            2'd1: begin n_rx = -n_by; n_ry = n_bx;  end
            2'd2: begin n_rx = -n_bx; n_ry = -n_by; end
            default: begin n_rx = n_by; n_ry = -n_bx; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv[0] <= 1'b0;
        end else if (en) begin
            r_rv[0] <= r_av;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rx[0]   <= n_rx;
            r_ry[0]   <= n_ry;
            r_rr[0]   <= t_cval'(n_rot - {n_rq[31:30], 30'd0});
            r_rsec[0] <= r_asec;
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rv[i+1] <= 1'b0;
            end else if (en) begin
                r_rv[i+1] <= r_rv[i];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                if (r_rr[i] >= 0) begin
                    r_rx[i+1] <= r_rx[i] - (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] + (r_rx[i] >>> i);
                    r_rr[i+1] <= r_rr[i] - t_cval'(atan_ent(5'(i)));
                end else begin
                    r_rx[i+1] <= r_rx[i] + (r_ry[i] >>> i);
                    r_ry[i+1] <= r_ry[i] - (r_rx[i] >>> i);
                    r_rr[i+1] <= r_rr[i] + t_cval'(atan_ent(5'(i)));
                end
                r_rsec[i+1] <= r_rsec[i];
            end
        end
    end

    // ------------------------------------------------------------- gain stage
    logic               r_mv;
    logic [2:0]         r_msec;
    logic signed [63:0] r_p1, r_p2, r_p3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else if (en) begin
            r_mv <= r_rv[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1   <= 64'(r_rx[N]) * 64'(GAIN_1P5);
            r_p2   <= 64'(r_ry[N]) * 64'(GAIN_HALF_SQRT3);
            r_p3   <= 64'(r_ry[N]) * 64'(GAIN_SQRT3);
            r_msec <= r_rsec[N];
        end
    end

    // --------------------------------------------------------- active times
    localparam logic signed [63:0] RND42 = 64'sd1 <<< 41;

    logic               r_tv;
    logic [2:0]         r_tsec;
    logic signed [21:0] r_t1, r_t2;
    logic signed [63:0] n_s1, n_s2;

    always_comb begin
        n_s1 = (r_p1 - r_p2 + RND42) >>> 42;
        n_s2 = (r_p3 + RND42) >>> 42;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv <= 1'b0;
        end else if (en) begin
            r_tv <= r_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1   <= n_s1[21:0];
            r_t2   <= n_s2[21:0];
            r_tsec <= r_msec;
        end
    end

    // ----------------------------------------------------------- phase build
    typedef logic signed [25:0] t_wide;

    function automatic logic [OUT_W-1:0] clamp_phase(input t_wide twice, input t_wide lim);
        t_wide v;
        v = (twice + t_wide'(1)) >>> 1;
        if (v < 0) begin
            v = '0;
        end
        if (v > lim) begin
            v = lim;
        end
        return v[OUT_W-1:0];
    endfunction

    t_wide n_lim, n_z0s, n_t1, n_t2, n_sa, n_sb, n_sc;

    always_comb begin
        n_lim = t_wide'({1'b0, r_limit});
        n_t1  = t_wide'(r_t1);
        n_t2  = t_wide'(r_t2);
        n_z0s = r_centered ? (n_lim - n_t1 - n_t2) : '0;
        unique case (r_tsec)
            3'd0: begin n_sa = n_t1 + n_t2; n_sb = n_t2;        n_sc = '0;          end
            3'd1: begin n_sa = n_t1;        n_sb = n_t1 + n_t2; n_sc = '0;          end
            3'd2: begin n_sa = '0;          n_sb = n_t1 + n_t2; n_sc = n_t2;        end
            3'd3: begin n_sa = '0;          n_sb = n_t1;        n_sc = n_t1 + n_t2; end
            3'd4: begin n_sa = n_t2;        n_sb = '0;          n_sc = n_t1 + n_t2; end
            default: begin n_sa = n_t1 + n_t2; n_sb = '0;       n_sc = n_t1;        end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_phase_a_volt  <= clamp_phase((n_sa <<< 1) + n_z0s, n_lim);
            o_phase_b_volt  <= clamp_phase((n_sb <<< 1) + n_z0s, n_lim);
            o_phase_c_volt  <= clamp_phase((n_sc <<< 1) + n_z0s, n_lim);
            o_sector_number <= r_tsec + 3'd1;
        end
    end

    assign o_out_valid = r_out_valid;

    // ------------------------------------------------------------- checks
    `SVP_ASSERT(a_sector_range, i_clk, i_rst_n, o_out_valid |-> (o_sector_number >= 3'd1 && o_sector_number <= 3'd6))
    `SVP_ASSERT(a_stall_only_full, i_clk, i_rst_n, o_in_stall |-> o_out_valid)
    `SVP_ASSERT(a_zero_limit, i_clk, i_rst_n, (o_out_valid && r_limit == '0) |-> (o_phase_a_volt == '0 && o_phase_b_volt == '0 && o_phase_c_volt == '0))
    `SVP_ASSERT_ALWAYS(a_reset_clears, i_clk, !$past(i_rst_n) |-> !r_out_valid)

endmodule

[bench/space_vector_pwm_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// space_vector_pwm_core_tb
// Drives voltage commands through the modulator, predicts the phase voltages
// and sector of each request and compares them with what comes out, across
// several limit and centering settings with random idling on both sides.
// ----------------------------------------------------------------------------
module space_vector_pwm_core_tb;
    import svpwm_pkg::*;

    localparam int STAGES   = 16;
    localparam int DRAIN    = 2 * STAGES + 12;
    localparam int WD_LIMIT = 4000;

    // atan(2^-i) in 2^-32 turn
    localparam bit [31:0] ATAN_TURN [0:15] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};

    typedef struct {
        bit [14:0] pa;
        bit [14:0] pb;
        bit [14:0] pc;
        bit [2:0]  sec;
    } phase_set_t;

    class phase_volt_board;
        phase_set_t pending_phases[$];
        longint     volt_limit = 24576;
        bit         centered = 1;
        int         mismatches = 0;

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            if (idx == CFG_SUPPLY_LIMIT) volt_limit = val;
            else if (idx == CFG_CENTERED) centered = val[0];
        endfunction

        function bit [31:0] command_angle(longint x, longint y);
            bit [31:0] z;
            longint dx, dy;
            z = 0;
            x = x * 4096;
            y = y * 4096;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = 32'h80000000;
            end
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += ATAN_TURN[i];
                end else begin
                    x -= dx; y += dy; z -= ATAN_TURN[i];
                end
            end
            return z;
        endfunction

        function void rotate(longint x, longint y, bit [31:0] ang,
                             output longint ox, output longint oy);
            longint qd, r, t, dx, dy;
            bit [31:0] rem;
            qd = ((longint'(ang) + 64'h20000000) >> 30) & 3;
            x = x * 4096;
            y = y * 4096;
            for (int k = 0; k < qd; k++) begin
                t = x; x = -y; y = t;
            end
            rem = ang - (32'(qd) << 30);
            r = longint'(signed'(rem));
            for (int i = 0; i < STAGES; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (r >= 0) begin
                    x -= dx; y += dy; r -= ATAN_TURN[i];
                end else begin
                    x += dx; y -= dy; r += ATAN_TURN[i];
                end
            end
            ox = x;
            oy = y;
        endfunction

        function bit [14:0] clamp_phase(longint twice);
            longint v;
            v = (twice + 1) >>> 1;
            if (v < 0) v = 0;
            if (v > volt_limit) v = volt_limit;
            return v[14:0];
        endfunction

        function void note_request(bit signed [15:0] q, bit signed [15:0] d, bit [15:0] e);
            longint vq, vd, off, theta, xv, yv, t1, t2, z0, sa, sb, sc;
            bit [31:0] rot;
            int sec;
            phase_set_t p;
            vq = q;
            vd = d;
            if (vd != 0) off = ((longint'(command_angle(vd, vq)) + 64'h8000) >> 16) & 16'hFFFF;
            else off = 16384;
            theta = (e + off) & 16'hFFFF;
            sec = int'((theta * 6) >> 16) + 1;
            rot = 32'((longint'(e) << 16) - 64'd715827883 * (sec - 1));
            rotate(vd, vq, rot, xv, yv);
            t1 = (xv * 978049311 - yv * 564677033 + (64'sd1 << 41)) >>> 42;
            t2 = (yv * 1129354066 + (64'sd1 << 41)) >>> 42;
            z0 = centered ? volt_limit - t1 - t2 : 0;
            case (sec)
                1: begin sa = t1 + t2; sb = t2;      sc = 0;       end
                2: begin sa = t1;      sb = t1 + t2; sc = 0;       end
                3: begin sa = 0;       sb = t1 + t2; sc = t2;      end
                4: begin sa = 0;       sb = t1;      sc = t1 + t2; end
                5: begin sa = t2;      sb = 0;       sc = t1 + t2; end
                default: begin sa = t1 + t2; sb = 0; sc = t1;      end
            endcase
            p.pa = clamp_phase(2 * sa + z0);
            p.pb = clamp_phase(2 * sb + z0);
            p.pc = clamp_phase(2 * sc + z0);
            p.sec = sec[2:0];
            pending_phases.push_back(p);
        endfunction

        function void check_result(bit [14:0] a, bit [14:0] b, bit [14:0] c, bit [2:0] s);
            phase_set_t p;
            if (pending_phases.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result a=%0d b=%0d c=%0d s=%0d",
                                               a, b, c, s);
                return;
            end
            p = pending_phases.pop_front();
            if (p.pa !== a || p.pb !== b || p.pc !== c || p.sec !== s) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp a=%0d b=%0d c=%0d s=%0d got a=%0d b=%0d c=%0d s=%0d",
                             p.pa, p.pb, p.pc, p.sec, a, b, c, s);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_in_valid = 0;
    logic o_in_stall;
    logic signed [15:0] i_volt_q = 0;
    logic signed [15:0] i_volt_d = 0;
    logic [15:0] i_elec_angle = 0;
    logic o_out_valid;
    logic i_out_stall = 0;
    logic [14:0] o_phase_a_volt, o_phase_b_volt, o_phase_c_volt;
    logic [2:0] o_sector_number;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;

    phase_volt_board board = new();
    bit long_hold = 0;
    int idle_cycles = 0;

    always #5 i_clk = ~i_clk;

    space_vector_pwm_core dut (.*);

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                board.check_result(o_phase_a_volt, o_phase_b_volt, o_phase_c_volt,
                                   o_sector_number);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WD_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // receiver: stall pattern in randomly chosen modes, plus one long hold
    initial begin
        int mode;
        forever begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 64; i++) begin
                @(negedge i_clk);
                if (long_hold) begin
                    i_out_stall <= 1;
                    repeat (300) @(negedge i_clk);
                    long_hold = 0;
                end
                case (mode)
                    0: i_out_stall <= 0;
                    1: i_out_stall <= ($urandom_range(0, 3) == 0);
                    2: i_out_stall <= ($urandom_range(0, 3) != 0);
                    default: i_out_stall <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // raise valid with a payload and hold until accepted; valid stays high
    task automatic send_cmd(bit [15:0] q, bit [15:0] d, bit [15:0] e);
        @(negedge i_clk);
        i_in_valid <= 1;
        i_volt_q <= q;
        i_volt_d <= d;
        i_elec_angle <= e;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(q, d, e);
    endtask

    task automatic pause_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 0;
            i_volt_q <= $urandom;
            i_volt_d <= $urandom;
            i_elec_angle <= $urandom;
        end
    endtask

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
    endtask

    task automatic release_cfg();
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    // wait for the pipeline to empty, then let it settle
    task automatic drain();
        pause_input(1);
        while (board.pending_phases.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic random_cmd();
        bit [15:0] q, d, e;
        q = $urandom;
        d = $urandom;
        e = $urandom;
        case ($urandom_range(0, 9))
            0: d = 0;
            1: begin q = $urandom_range(0, 64) - 32; d = $urandom_range(0, 64) - 32; end
            2: q = 0;
            default: ;
        endcase
        send_cmd(q, d, e);
    endtask

    task automatic random_run(int n, bit with_hold);
        int sent, burst;
        bit gapless;
        sent = 0;
        gapless = 0;
        while (sent < n) begin
            if ($urandom_range(0, 7) == 0) gapless = ~gapless;
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < n; i++) begin
                if (with_hold && sent == n / 2) long_hold = 1;
                random_cmd();
                sent++;
            end
            if (!gapless) pause_input($urandom_range(1, 6));
        end
    endtask

    task automatic directed_run();
        send_cmd(16'h7FFF, 16'h7FFF, 16'h0000);
        send_cmd(16'h8000, 16'h8000, 16'hFFFF);
        send_cmd(16'h7FFF, 16'h8000, 16'h8000);
        send_cmd(16'h8000, 16'h7FFF, 16'h4000);
        send_cmd(16'h4000, 16'h0000, 16'h0000);
        send_cmd(16'hC000, 16'h0000, 16'h0000);
        send_cmd(16'h8000, 16'h0000, 16'h2AAA);
        send_cmd(16'h0000, 16'h0000, 16'h1234);
        send_cmd(16'h0000, 16'h0400, 16'hFFFF);
        send_cmd(16'h0000, 16'hFC00, 16'h5555);
        send_cmd(16'h0001, 16'hFFFF, 16'hAAAA);
        for (int s = 0; s < 6; s++)
            send_cmd(16'h1000, 16'h0000, 16'(s * 10923 + 100));
        send_cmd(16'h2000, 16'h0000, 16'h2AAB);
        send_cmd(16'h2000, 16'h0000, 16'h2AAA);
        pause_input(3);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        directed_run();
        random_run(700, 1);
        drain();

        write_reg(CFG_SUPPLY_LIMIT, 15'h7FFF);
        write_reg(CFG_CENTERED, 15'h0000);
        release_cfg();
        directed_run();
        random_run(300, 0);
        drain();

        write_reg(CFG_SUPPLY_LIMIT, 15'h0000);
        write_reg(CFG_CENTERED, 15'h7FFF);
        write_reg(2'd2, 15'h1234);
        write_reg(2'd3, 15'h0000);
        release_cfg();
        random_run(150, 0);
        drain();

        write_reg(CFG_SUPPLY_LIMIT, 15'd1000);
        write_reg(CFG_CENTERED, 15'h0000);
        release_cfg();
        random_run(300, 0);
        drain();

        write_reg(CFG_SUPPLY_LIMIT, 15'h7FFF);
        write_reg(CFG_CENTERED, 15'h0001);
        release_cfg();
        directed_run();
        random_run(450, 0);
        drain();

        if (board.mismatches == 0 && board.pending_phases.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/svpwm_pkg.sv
rtl/space_vector_pwm_core.sv
bench/space_vector_pwm_core_tb.sv
